// ===== hdl/gda_pkg.sv =====
package gda_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_DAYS,
    ST_MONTHS,
    ST_YEARS,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MODE_DAYS    = 3'd0,
    MODE_WEEKS   = 3'd1,
    MODE_MONTHS  = 3'd2,
    MODE_YEARS   = 3'd3,
    MODE_DECADES = 3'd4
  } mode_t;

  localparam int YEAR_W  = 15;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int REM_W   = 9;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 15'd32767;
  localparam logic [YEAR_W-1:0]  CYCLE_LEN  = 15'd400;
  localparam logic [YEAR_W-1:0]  CYCLE_LAST = 15'd399;
  localparam logic [2:0]         REDUCE_TOP = 3'd6;
  localparam logic [MONTH_W-1:0] JAN        = 4'd1;
  localparam logic [MONTH_W-1:0] FEB        = 4'd2;
  localparam logic [MONTH_W-1:0] DEC        = 4'd12;
  localparam logic [DAY_W-1:0]   FEB_LEAP   = 5'd29;
  localparam logic [DAY_W-1:0]   FEB_PLAIN  = 5'd28;
  localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;

  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // year mod 400 -> leap (divisible by 4, and not by 100 unless by 400)
  function automatic logic is_leap(input logic [REM_W-1:0] r);
    return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    if (m == FEB) begin
      len = leap ? FEB_LEAP : FEB_PLAIN;
    end else if (m >= JAN && m <= DEC) begin
      len = MONTH_DAYS[m - JAN];
    end
    return len;
  endfunction

endpackage

// ===== hdl/gregorian_date_adder_unit.sv =====
// Gregorian date adder.
// Input stream: s_axis_tuser carries the mode (0 days, 1 weeks, 2 months,
// 3 years, 4 decades); s_axis_tdata carries amount, year, month and day.
// Output stream: m_axis-style result with the shifted date in m_axis_tdata
// and the overflow / invalid-date flags in m_axis_tuser.
// One request is worked at a time; s_axis_tready is high only while idle.
// The year is first reduced mod 400 by a shared compare-subtract unit,
// then one day or one month is advanced per cycle in the day, week and
// month modes; year and decade modes add the amount directly and reduce
// the new year again. The worst case is 32767 weeks, set by the
// one-day-per-cycle step loop. Invalid dates and unknown modes skip the
// step loop.
// The result sits in an output register; a new request is taken as soon
// as the unit is idle, even while the last result still waits. If the
// receiver stalls, the next result holds in its final state until the
// output register frees up.
// Reset (rst, synchronous) returns the unit to idle and drops any result.
module gregorian_date_adder_unit #(
  parameter int COUNT_WIDTH = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [14:0] amount, [29:15] in_year, [33:30] in_month, [38:34] in_day
  input  logic [39:0] s_axis_tdata,
  // [2:0] mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] out_year, [18:15] out_month, [23:19] out_day
  output logic [23:0] m_axis_tdata,
  // [0] year_overflow, [1] bad_date
  output logic [1:0]  m_axis_tuser
);

  localparam int STEP_W = COUNT_WIDTH + 4;
  localparam int SUM_W  = ((STEP_W > gda_pkg::YEAR_W) ? STEP_W : gda_pkg::YEAR_W) + 1;

  gda_pkg::state_t state, state_next;

  logic [2:0]                   mode, mode_next;
  logic [STEP_W-1:0]            steps, steps_next;
  logic [gda_pkg::YEAR_W-1:0]   year, year_next;
  logic [gda_pkg::MONTH_W-1:0]  month, month_next;
  logic [gda_pkg::DAY_W-1:0]    day, day_next;
  logic [gda_pkg::YEAR_W-1:0]   rem, rem_next;
  logic [2:0]                   shift, shift_next;
  logic                         second, second_next;
  logic                         ovf, ovf_next;
  logic                         bad, bad_next;
  logic                         load_out;

  logic [gda_pkg::YEAR_W-1:0]   divisor;
  logic [gda_pkg::YEAR_W-1:0]   rem_inc;
  logic                         leap_cur;
  logic [gda_pkg::DAY_W-1:0]    mlen_cur;
  logic [gda_pkg::MONTH_W-1:0]  month_inc;
  logic                         leap_inc;
  logic [gda_pkg::DAY_W-1:0]    mlen_inc;
  logic [SUM_W-1:0]             year_sum;

  assign divisor   = gda_pkg::CYCLE_LEN << shift;
  assign rem_inc   = (rem == gda_pkg::CYCLE_LAST) ? '0 : rem + 1'b1;
  assign leap_cur  = gda_pkg::is_leap(rem[gda_pkg::REM_W-1:0]);
  assign mlen_cur  = gda_pkg::month_len(month, leap_cur);
  assign month_inc = (month == gda_pkg::DEC) ? gda_pkg::JAN : month + 1'b1;
  assign leap_inc  = (month == gda_pkg::DEC) ? gda_pkg::is_leap(rem_inc[gda_pkg::REM_W-1:0])
                                             : leap_cur;
  assign mlen_inc  = gda_pkg::month_len(month_inc, leap_inc);
  assign year_sum  = SUM_W'(year) + SUM_W'(steps);

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    steps_next    = steps;
    year_next     = year;
    month_next    = month;
    day_next      = day;
    rem_next      = rem;
    shift_next    = shift;
    second_next   = second;
    ovf_next      = ovf;
    bad_next      = bad;
    load_out      = 1'b0;
    s_axis_tready = (state == gda_pkg::ST_IDLE);

    unique case (state)
      gda_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_next   = s_axis_tuser;
          steps_next  = STEP_W'(s_axis_tdata[COUNT_WIDTH-1:0]);
          year_next   = s_axis_tdata[29:15];
          month_next  = s_axis_tdata[33:30];
          day_next    = s_axis_tdata[38:34];
          rem_next    = s_axis_tdata[29:15];
          shift_next  = gda_pkg::REDUCE_TOP;
          second_next = 1'b0;
          ovf_next    = 1'b0;
          bad_next    = 1'b0;
          state_next  = gda_pkg::ST_REDUCE;
        end
      end

      gda_pkg::ST_REDUCE: begin
        if (rem >= divisor) begin
          rem_next = rem - divisor;
        end
        shift_next = shift - 1'b1;
        if (shift == '0) begin
          state_next = second ? gda_pkg::ST_FIX : gda_pkg::ST_CHECK;
        end
      end

      gda_pkg::ST_CHECK: begin
        if (day == '0 || day > mlen_cur) begin
          bad_next   = 1'b1;
          state_next = gda_pkg::ST_DONE;
        end else begin
          unique case (mode)
            gda_pkg::MODE_DAYS: begin
              state_next = gda_pkg::ST_DAYS;
            end
            gda_pkg::MODE_WEEKS: begin
              steps_next = (steps << 3) - steps;
              state_next = gda_pkg::ST_DAYS;
            end
            gda_pkg::MODE_MONTHS: begin
              state_next = gda_pkg::ST_MONTHS;
            end
            gda_pkg::MODE_YEARS: begin
              state_next = gda_pkg::ST_YEARS;
            end
            gda_pkg::MODE_DECADES: begin
              steps_next = (steps << 3) + (steps << 1);
              state_next = gda_pkg::ST_YEARS;
            end
            default: begin
              state_next = gda_pkg::ST_DONE;
            end
          endcase
        end
      end

      gda_pkg::ST_DAYS: begin
        if (steps == '0) begin
          state_next = gda_pkg::ST_DONE;
        end else if (day >= mlen_cur) begin
          if (month == gda_pkg::DEC && year == gda_pkg::YEAR_MAX) begin
            ovf_next   = 1'b1;
            state_next = gda_pkg::ST_DONE;
          end else begin
            if (month == gda_pkg::DEC) begin
              year_next = year + 1'b1;
              rem_next  = rem_inc;
            end
            month_next = month_inc;
            day_next   = gda_pkg::FIRST_DAY;
            steps_next = steps - 1'b1;
          end
        end else begin
          day_next   = day + 1'b1;
          steps_next = steps - 1'b1;
        end
      end

      gda_pkg::ST_MONTHS: begin
        if (steps == '0) begin
          state_next = gda_pkg::ST_DONE;
        end else if (month == gda_pkg::DEC && year == gda_pkg::YEAR_MAX) begin
          ovf_next   = 1'b1;
          state_next = gda_pkg::ST_DONE;
        end else begin
          if (month == gda_pkg::DEC) begin
            year_next = year + 1'b1;
            rem_next  = rem_inc;
          end
          month_next = month_inc;
          if (day > mlen_inc) begin
            day_next = mlen_inc;
          end
          steps_next = steps - 1'b1;
        end
      end

      gda_pkg::ST_YEARS: begin
        if (year_sum > SUM_W'(gda_pkg::YEAR_MAX)) begin
          year_next = gda_pkg::YEAR_MAX;
          rem_next  = gda_pkg::YEAR_MAX;
          ovf_next  = 1'b1;
        end else begin
          year_next = year_sum[gda_pkg::YEAR_W-1:0];
          rem_next  = year_sum[gda_pkg::YEAR_W-1:0];
        end
        shift_next  = gda_pkg::REDUCE_TOP;
        second_next = 1'b1;
        state_next  = gda_pkg::ST_REDUCE;
      end

      gda_pkg::ST_FIX: begin
        if (month == gda_pkg::FEB && day == gda_pkg::FEB_LEAP && !leap_cur) begin
          day_next = gda_pkg::FEB_PLAIN;
        end
        state_next = gda_pkg::ST_DONE;
      end

      gda_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = gda_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = gda_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gda_pkg::ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode   <= mode_next;
    steps  <= steps_next;
    year   <= year_next;
    month  <= month_next;
    day    <= day_next;
    rem    <= rem_next;
    shift  <= shift_next;
    second <= second_next;
    ovf    <= ovf_next;
    bad    <= bad_next;
    if (load_out) begin
      m_axis_tdata <= {day, month, year};
      m_axis_tuser <= {bad, ovf};
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AMOUNT_W = 15;
  localparam int RANDOM_ITEMS = 74;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_AFTER = 40;
  localparam int HOLD_CYCLES = 500;

  localparam logic [2:0] MODE_RSV_5 = 3'd5;
  localparam logic [2:0] MODE_RSV_6 = 3'd6;
  localparam logic [2:0] MODE_RSV_7 = 3'd7;

  localparam int SEND_IDLE [3] = '{27, 76, 0};
  localparam int RECV_IDLE [3] = '{76, 27, 0};

  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [2:0]                  mode;
    logic [AMOUNT_W-1:0]         amount;
    logic [gda_pkg::YEAR_W-1:0]  year;
    logic [gda_pkg::MONTH_W-1:0] month;
    logic [gda_pkg::DAY_W-1:0]   day;
  } date_req_t;

  typedef struct packed {
    logic [gda_pkg::YEAR_W-1:0]  year;
    logic [gda_pkg::MONTH_W-1:0] month;
    logic [gda_pkg::DAY_W-1:0]   day;
    logic                        ovf;
    logic                        bad;
  } date_res_t;

  typedef struct packed {
    logic [2:0]                  mode;
    logic [AMOUNT_W-1:0]         amount;
    logic [gda_pkg::YEAR_W-1:0]  year;
    logic [gda_pkg::MONTH_W-1:0] month;
    logic [gda_pkg::DAY_W-1:0]   day;
    logic                        typed;
    logic [gda_pkg::YEAR_W-1:0]  e_year;
    logic [gda_pkg::MONTH_W-1:0] e_month;
    logic [gda_pkg::DAY_W-1:0]   e_day;
    logic                        e_ovf;
    logic                        e_bad;
  } row_t;

  localparam row_t DIRECTED_ROWS [26] = '{
    '{gda_pkg::MODE_DAYS,    15'd0,     15'd2024,  4'd2,  5'd29,
      1'b1, 15'd2024,  4'd2,  5'd29, 1'b0, 1'b0},
    '{gda_pkg::MODE_DAYS,    15'd1,     15'd2023,  4'd12, 5'd31,
      1'b1, 15'd2024,  4'd1,  5'd1,  1'b0, 1'b0},
    '{gda_pkg::MODE_DAYS,    15'd1,     15'd2024,  4'd2,  5'd28,
      1'b1, 15'd2024,  4'd2,  5'd29, 1'b0, 1'b0},
    '{gda_pkg::MODE_DAYS,    15'd1,     15'd1900,  4'd2,  5'd28,
      1'b1, 15'd1900,  4'd3,  5'd1,  1'b0, 1'b0},
    '{gda_pkg::MODE_DAYS,    15'd1,     15'd2000,  4'd2,  5'd28,
      1'b1, 15'd2000,  4'd2,  5'd29, 1'b0, 1'b0},
    '{gda_pkg::MODE_DAYS,    15'd32767, 15'd0,     4'd1,  5'd1,
      1'b0, 15'd0,     4'd0,  5'd0,  1'b0, 1'b0},
    '{gda_pkg::MODE_WEEKS,   15'd32767, 15'd1,     4'd1,  5'd1,
      1'b0, 15'd0,     4'd0,  5'd0,  1'b0, 1'b0},
    '{gda_pkg::MODE_WEEKS,   15'd1,     15'd32767, 4'd12, 5'd31,
      1'b1, 15'd32767, 4'd12, 5'd31, 1'b1, 1'b0},
    '{gda_pkg::MODE_DAYS,    15'd5,     15'd32767, 4'd12, 5'd30,
      1'b1, 15'd32767, 4'd12, 5'd31, 1'b1, 1'b0},
    '{gda_pkg::MODE_MONTHS,  15'd1,     15'd2023,  4'd1,  5'd31,
      1'b1, 15'd2023,  4'd2,  5'd28, 1'b0, 1'b0},
    '{gda_pkg::MODE_MONTHS,  15'd1,     15'd2024,  4'd1,  5'd31,
      1'b1, 15'd2024,  4'd2,  5'd29, 1'b0, 1'b0},
    '{gda_pkg::MODE_MONTHS,  15'd32767, 15'd0,     4'd1,  5'd1,
      1'b0, 15'd0,     4'd0,  5'd0,  1'b0, 1'b0},
    '{gda_pkg::MODE_MONTHS,  15'd3,     15'd32767, 4'd11, 5'd30,
      1'b1, 15'd32767, 4'd12, 5'd30, 1'b1, 1'b0},
    '{gda_pkg::MODE_YEARS,   15'd1,     15'd2024,  4'd2,  5'd29,
      1'b1, 15'd2025,  4'd2,  5'd28, 1'b0, 1'b0},
    '{gda_pkg::MODE_YEARS,   15'd4,     15'd2024,  4'd2,  5'd29,
      1'b1, 15'd2028,  4'd2,  5'd29, 1'b0, 1'b0},
    '{gda_pkg::MODE_YEARS,   15'd32767, 15'd1,     4'd3,  5'd15,
      1'b1, 15'd32767, 4'd3,  5'd15, 1'b1, 1'b0},
    '{gda_pkg::MODE_DECADES, 15'd32767, 15'd0,     4'd2,  5'd29,
      1'b1, 15'd32767, 4'd2,  5'd28, 1'b1, 1'b0},
    '{gda_pkg::MODE_DECADES, 15'd10,    15'd1900,  4'd2,  5'd28,
      1'b1, 15'd2000,  4'd2,  5'd28, 1'b0, 1'b0},
    '{gda_pkg::MODE_YEARS,   15'd0,     15'd32767, 4'd12, 5'd31,
      1'b1, 15'd32767, 4'd12, 5'd31, 1'b0, 1'b0},
    '{gda_pkg::MODE_DAYS,    15'd5,     15'd2000,  4'd0,  5'd10,
      1'b1, 15'd2000,  4'd0,  5'd10, 1'b0, 1'b1},
    '{gda_pkg::MODE_MONTHS,  15'd9,     15'd1999,  4'd15, 5'd31,
      1'b1, 15'd1999,  4'd15, 5'd31, 1'b0, 1'b1},
    '{gda_pkg::MODE_WEEKS,   15'd2,     15'd2010,  4'd6,  5'd0,
      1'b1, 15'd2010,  4'd6,  5'd0,  1'b0, 1'b1},
    '{gda_pkg::MODE_YEARS,   15'd1,     15'd2023,  4'd2,  5'd29,
      1'b1, 15'd2023,  4'd2,  5'd29, 1'b0, 1'b1},
    '{MODE_RSV_5,            15'd100,   15'd2020,  4'd5,  5'd5,
      1'b1, 15'd2020,  4'd5,  5'd5,  1'b0, 1'b0},
    '{MODE_RSV_7,            15'd32767, 15'd2021,  4'd2,  5'd29,
      1'b1, 15'd2021,  4'd2,  5'd29, 1'b0, 1'b1},
    '{MODE_RSV_6,            15'd1,     15'd2020,  4'd12, 5'd31,
      1'b1, 15'd2020,  4'd12, 5'd31, 1'b0, 1'b0}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  date_res_t   expected_dates [$];
  int          phase = 0;
  int          fail_count = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          held = 1'b0;
  int unsigned cycle_count = 0;

  gregorian_date_adder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    if (m < 1 || m > 12) begin
      return 0;
    end
    if (m == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    return MONTH_LEN[m-1];
  endfunction

  function automatic bit walk_days(input int unsigned n, inout int unsigned y,
                                   inout int unsigned m, inout int unsigned d);
    for (int unsigned i = 0; i < n; i++) begin
      if (d >= days_in_month(m, y)) begin
        if (m == 12) begin
          if (y >= 32'(gda_pkg::YEAR_MAX)) begin
            return 1'b1;
          end
          y = y + 1;
          m = 1;
        end else begin
          m = m + 1;
        end
        d = 1;
      end else begin
        d = d + 1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit jump_years(input int unsigned n, inout int unsigned y,
                                    inout int unsigned m, inout int unsigned d);
    int unsigned ny;
    bit          ovf;
    ny = y + n;
    ovf = 1'b0;
    if (ny > 32'(gda_pkg::YEAR_MAX)) begin
      ny = 32'(gda_pkg::YEAR_MAX);
      ovf = 1'b1;
    end
    y = ny;
    if (m == 2 && d == 29 && !leap_year(ny)) begin
      d = 28;
    end
    return ovf;
  endfunction

  function automatic date_res_t shifted_date(input date_req_t r);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned n;
    bit          ovf;
    bit          bad;
    date_res_t   res;
    y = 32'(r.year);
    m = 32'(r.month);
    d = 32'(r.day);
    n = 32'(r.amount);
    ovf = 1'b0;
    bad = (m < 1 || m > 12 || d < 1 || d > days_in_month(m, y));
    if (!bad) begin
      case (r.mode)
        gda_pkg::MODE_DAYS:    ovf = walk_days(n, y, m, d);
        gda_pkg::MODE_WEEKS:   ovf = walk_days(n * 7, y, m, d);
        gda_pkg::MODE_MONTHS: begin
          for (int unsigned i = 0; i < n && !ovf; i++) begin
            if (m == 12) begin
              if (y >= 32'(gda_pkg::YEAR_MAX)) begin
                ovf = 1'b1;
              end else begin
                y = y + 1;
                m = 1;
              end
            end else begin
              m = m + 1;
            end
            if (!ovf && d > days_in_month(m, y)) begin
              d = days_in_month(m, y);
            end
          end
        end
        gda_pkg::MODE_YEARS:   ovf = jump_years(n, y, m, d);
        gda_pkg::MODE_DECADES: ovf = jump_years(n * 10, y, m, d);
        default: ;
      endcase
    end
    res.year = gda_pkg::YEAR_W'(y);
    res.month = gda_pkg::MONTH_W'(m);
    res.day = gda_pkg::DAY_W'(d);
    res.ovf = ovf;
    res.bad = bad;
    return res;
  endfunction

  task automatic offer(input date_req_t r, input date_res_t want);
    while ($urandom_range(99) < SEND_IDLE[phase]) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, r.day, r.month, r.year, r.amount};
    s_axis_tuser <= r.mode;
    do @(posedge clk); while (!s_axis_tready);
    expected_dates.push_back(want);
  endtask

  task automatic settle_queue();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_dates.size() != 0);
  endtask

  always @(posedge clk) begin
    date_res_t got;
    date_res_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.year = m_axis_tdata[14:0];
        got.month = m_axis_tdata[18:15];
        got.day = m_axis_tdata[23:19];
        got.ovf = m_axis_tuser[0];
        got.bad = m_axis_tuser[1];
        results_seen++;
        if (expected_dates.size() == 0) begin
          $error("result with no request outstanding: %0d-%0d-%0d",
                 got.year, got.month, got.day);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          if (got.year !== want.year) begin
            $error("out_year: expected %0d, got %0d", want.year, got.year);
            fail_count++;
          end
          if (got.month !== want.month) begin
            $error("out_month: expected %0d, got %0d", want.month, got.month);
            fail_count++;
          end
          if (got.day !== want.day) begin
            $error("out_day: expected %0d, got %0d", want.day, got.day);
            fail_count++;
          end
          if (got.ovf !== want.ovf) begin
            $error("year_overflow: expected %0d, got %0d", want.ovf, got.ovf);
            fail_count++;
          end
          if (got.bad !== want.bad) begin
            $error("bad_date: expected %0d, got %0d", want.bad, got.bad);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (results_seen == HOLD_AFTER && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= RECV_IDLE[phase]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** gregorian_date_adder_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    date_req_t   req;
    date_res_t   want;
    int unsigned pick;
    int unsigned span;
    bit          big;
    int          big_left;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    big_left = 3;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      req.mode = DIRECTED_ROWS[i].mode;
      req.amount = DIRECTED_ROWS[i].amount;
      req.year = DIRECTED_ROWS[i].year;
      req.month = DIRECTED_ROWS[i].month;
      req.day = DIRECTED_ROWS[i].day;
      if (DIRECTED_ROWS[i].typed) begin
        want.year = DIRECTED_ROWS[i].e_year;
        want.month = DIRECTED_ROWS[i].e_month;
        want.day = DIRECTED_ROWS[i].e_day;
        want.ovf = DIRECTED_ROWS[i].e_ovf;
        want.bad = DIRECTED_ROWS[i].e_bad;
      end else begin
        want = shifted_date(req);
      end
      offer(req, want);
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3 || k == 2 * RANDOM_ITEMS / 3) begin
        settle_queue();
        phase++;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        req.mode = MODE_RSV_5 + 3'($urandom_range(2));
      end else begin
        req.mode = 3'($urandom_range(int'(gda_pkg::MODE_DECADES)));
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        req.year = gda_pkg::YEAR_W'($urandom_range(32767, 32700));
      end else if (pick < 45) begin
        req.year = gda_pkg::YEAR_W'($urandom_range(2104, 1896));
      end else begin
        req.year = gda_pkg::YEAR_W'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        req.month = gda_pkg::MONTH_W'($urandom);
        req.day = gda_pkg::DAY_W'($urandom);
      end else if (pick < 22) begin
        req.month = gda_pkg::FEB;
        req.day = gda_pkg::FEB_LEAP;
      end else begin
        req.month = gda_pkg::MONTH_W'($urandom_range(12, 1));
        req.day = gda_pkg::DAY_W'($urandom_range(
                    days_in_month(32'(req.month), 32'(req.year)), 1));
      end
      big = (big_left > 0) && ($urandom_range(19) == 0);
      if (big) begin
        big_left--;
      end
      pick = $urandom_range(99);
      case (req.mode) inside
        gda_pkg::MODE_YEARS, gda_pkg::MODE_DECADES:
          span = ($urandom_range(1) == 1) ? 32767 : 60;
        gda_pkg::MODE_WEEKS:
          span = big ? 4681 : ((pick < 10) ? 300 : 30);
        default:
          span = big ? 32767 : ((pick < 10) ? 2000 : 200);
      endcase
      req.amount = AMOUNT_W'($urandom_range(span, 0));
      offer(req, shifted_date(req));
    end

    settle_queue();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_dates.size() == 0) begin
      $display("** gregorian_date_adder_unit: PASSED **");
    end else begin
      $display("** gregorian_date_adder_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gda_pkg.sv
hdl/gregorian_date_adder_unit.sv
tb/tb_top.sv
